@@ hw/rtl/jacobi_sequence_with_derivatives_core_assert.svh @@
// Assertion macros for the Jacobi sequence core.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef JACOBI_SEQUENCE_WITH_DERIVATIVES_CORE_ASSERT_SVH
`define JACOBI_SEQUENCE_WITH_DERIVATIVES_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JSWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define JSWD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define JSWD_ASSERT(lbl, prop, msg)
`define JSWD_NEVER(lbl, expr, msg)
`endif
`endif

@@ hw/rtl/jswd_pkg.sv @@
// Shared widths, types and the sequencer micro-program of the Jacobi core.
// No dependencies.
`timescale 1ns / 1ps
package jswd_pkg;
	localparam int unsigned MAX_DEGREE_DEF = 63;
	localparam int unsigned VW = 64;
	localparam int unsigned NW = 128;
	localparam int unsigned SW = 20;
	localparam int unsigned UPC_W = 5;
	localparam logic [UPC_W-1:0] UPC_INIT = 5'd0;
	localparam logic [UPC_W-1:0] UPC_STEP = 5'd5;

	// UK_SHR: rounded shift of the accumulator, scale chosen by the b operand
	typedef enum logic [1:0] {UK_MAC, UK_DIV, UK_SHR} ukind_t;

	typedef enum logic [4:0] {
		OP_A, OP_B, OP_AMB, OP_AB512, OP_X, OP_P30, OP_128, OP_T, OP_T256, OP_T512,
		OP_K1, OP_KAB, OP_KA, OP_KB, OP_U, OP_S, OP_S2, OP_E, OP_BC, OP_C, OP_D,
		OP_PC, OP_PM, OP_DC, OP_DM, OP_EC, OP_EM
	} opsel_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_U, DST_S, DST_D, DST_C, DST_E, DST_F, DST_BC, DST_P1,
		DST_PN, DST_DN, DST_EN
	} dst_t;

	typedef struct packed {
		ukind_t kind;
		opsel_t opa;
		opsel_t opb;
		logic   clr;
		logic   sub;
		dst_t   dst;
		logic   last;
	} uop_t;

	typedef struct packed {
		logic start;
		logic clr;
		logic sub;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_sts_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic sat;
	} div_sts_t;

	// Degree one at 0..4, one recurrence step at 5..24.
	function automatic uop_t uop_rom(input logic [UPC_W-1:0] upc);
		uop_t u;
		unique case (upc)
			5'd0:  u = '{UK_MAC, OP_A,     OP_A,    1'b1, 1'b0, DST_NONE, 1'b0};
			5'd1:  u = '{UK_MAC, OP_B,     OP_B,    1'b0, 1'b1, DST_E,    1'b0};
			5'd2:  u = '{UK_MAC, OP_AMB,   OP_P30,  1'b1, 1'b0, DST_NONE, 1'b0};
			5'd3:  u = '{UK_MAC, OP_AB512, OP_X,    1'b0, 1'b0, DST_NONE, 1'b0};
			5'd4:  u = '{UK_SHR, OP_X,     OP_128,  1'b0, 1'b0, DST_P1,   1'b1};
			5'd5:  u = '{UK_MAC, OP_T256,  OP_T512, 1'b1, 1'b0, DST_U,    1'b0};
			5'd6:  u = '{UK_MAC, OP_U,     OP_T,    1'b1, 1'b0, DST_S,    1'b0};
			5'd7:  u = '{UK_MAC, OP_K1,    OP_KAB,  1'b1, 1'b0, DST_U,    1'b0};
			5'd8:  u = '{UK_MAC, OP_U,     OP_T,    1'b1, 1'b0, DST_D,    1'b0};
			5'd9:  u = '{UK_MAC, OP_KA,    OP_KB,   1'b1, 1'b0, DST_U,    1'b0};
			5'd10: u = '{UK_MAC, OP_U,     OP_T512, 1'b1, 1'b0, DST_C,    1'b0};
			5'd11: u = '{UK_MAC, OP_T256,  OP_E,    1'b1, 1'b0, DST_F,    1'b0};
			5'd12: u = '{UK_MAC, OP_S,     OP_X,    1'b1, 1'b0, DST_NONE, 1'b0};
			5'd13: u = '{UK_SHR, OP_X,     OP_P30,  1'b0, 1'b0, DST_BC,   1'b0};
			5'd14: u = '{UK_MAC, OP_BC,    OP_PC,   1'b1, 1'b0, DST_NONE, 1'b0};
			5'd15: u = '{UK_MAC, OP_C,     OP_PM,   1'b0, 1'b1, DST_NONE, 1'b0};
			5'd16: u = '{UK_DIV, OP_X,     OP_D,    1'b0, 1'b0, DST_PN,   1'b0};
			5'd17: u = '{UK_MAC, OP_S,     OP_PC,   1'b1, 1'b0, DST_NONE, 1'b0};
			5'd18: u = '{UK_MAC, OP_BC,    OP_DC,   1'b0, 1'b0, DST_NONE, 1'b0};
			5'd19: u = '{UK_MAC, OP_C,     OP_DM,   1'b0, 1'b1, DST_NONE, 1'b0};
			5'd20: u = '{UK_DIV, OP_X,     OP_D,    1'b0, 1'b0, DST_DN,   1'b0};
			5'd21: u = '{UK_MAC, OP_S2,    OP_DC,   1'b1, 1'b0, DST_NONE, 1'b0};
			5'd22: u = '{UK_MAC, OP_BC,    OP_EC,   1'b0, 1'b0, DST_NONE, 1'b0};
			5'd23: u = '{UK_MAC, OP_C,     OP_EM,   1'b0, 1'b1, DST_NONE, 1'b0};
			5'd24: u = '{UK_DIV, OP_X,     OP_D,    1'b0, 1'b0, DST_EN,   1'b1};
			default: u = '{UK_MAC, OP_X,   OP_X,    1'b1, 1'b0, DST_NONE, 1'b1};
		endcase
		return u;
	endfunction
endpackage

@@ hw/rtl/jswd_in_if.sv @@
// Input channel of the Jacobi core: valid/ready plus one item.
// Depends on nothing.
`timescale 1ns / 1ps
interface jswd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point;
	logic [5:0]         top_degree;
	logic signed [14:0] alpha_param;
	logic signed [14:0] beta_param;

	modport source(output valid, point, top_degree, alpha_param, beta_param, input ready);
	modport sink(input valid, point, top_degree, alpha_param, beta_param, output ready);
endinterface

@@ hw/rtl/jswd_out_if.sv @@
// Result channel of the Jacobi core: valid/ready plus one item.
// Depends on nothing.
`timescale 1ns / 1ps
interface jswd_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         degree;
	logic signed [63:0] poly_value;
	logic signed [63:0] first_deriv;
	logic signed [63:0] second_deriv;
	logic               saturated;
	logic               last;

	modport source(output valid, degree, poly_value, first_deriv, second_deriv, saturated,
		last, input ready);
	modport sink(input valid, degree, poly_value, first_deriv, second_deriv, saturated,
		last, output ready);
endinterface

@@ hw/rtl/jacobi_sequence_with_derivatives_core.sv @@
// Jacobi polynomial sequence with first and second derivatives.
// Channel sample takes one item: point x (Q2.30), top degree n, alpha and
// beta (Q7.8). Channel result returns n+1 items, degree 0 to n, each with
// P, P' and P'' in Q32.32, a saturation flag and last on degree n.
// Degree 0 passes from the emit state into the output register once that
// register is free. Degree 1 is built from multiply-accumulates and one
// rounding shift; every later degree takes sixteen multiply-accumulates on
// the shared 32x32 multiplier, three rounded divisions on the bit-serial
// divider and one rounding shift.
// sample.ready is high only while the block is idle; one item is in work
// at a time. Each result sits in an output register; if the receiver
// stalls, the sequencer holds before loading the next result, and a new
// item may be taken while the last result still waits.
// Reset clears the sequencer and the output valid; no clearing pass.
// Depends on jswd_pkg, jswd_in_if, jswd_out_if, jswd_mac, jswd_div.
`timescale 1ns / 1ps
`include "jacobi_sequence_with_derivatives_core_assert.svh"
module jacobi_sequence_with_derivatives_core import jswd_pkg::*; #(
	parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
	input logic      clk,
	input logic      arst_n,
	jswd_in_if.sink  sample,
	jswd_out_if.source result
);
	localparam int unsigned KW = $clog2(MAX_DEGREE + 1);
	localparam logic signed [SW-1:0] C256 = SW'(256);
	localparam logic signed [SW-1:0] C512 = SW'(512);
	localparam logic signed [VW-1:0] ONE_Q32 = 64'sh1_0000_0000;
	localparam logic signed [VW-1:0] P30 = 64'sh4000_0000;
	localparam logic signed [VW-1:0] D128 = 64'sd128;
	localparam logic [NW-1:0] RND30_POS = NW'(64'h2000_0000);
	localparam logic [NW-1:0] RND30_NEG = NW'(64'h1fff_ffff);
	localparam logic [NW-1:0] RND7_POS  = NW'(64'd64);
	localparam logic [NW-1:0] RND7_NEG  = NW'(64'd63);
	localparam logic signed [VW-1:0] Q_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] Q_MIN = {1'b1, {(VW-1){1'b0}}};

	typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_RUN} state_t;

	state_t               state_q;
	logic [UPC_W-1:0]     upc_q;
	logic                 issued_q;
	logic [KW-1:0]        k_q, n_q;
	logic signed [31:0]   x_q;
	logic signed [14:0]   a_q, b_q;
	logic signed [VW-1:0] u_q, s_q, d_q, c_q, f_q, bc_q;
	logic signed [31:0]   e_q;
	logic signed [VW-1:0] pc_q, pm_q, dc_q, dm_q, ec_q, em_q, pn_q, dn_q;
	logic                 sat_q;
	logic                 ov_q, o_sat_q, o_last_q;
	logic [5:0]           o_deg_q;
	logic signed [VW-1:0] o_p_q, o_d_q, o_e_q;

	logic signed [SW-1:0] k_s, a_s, b_s, t_s, t256, t512, k1, kab, ka, kb, amb, ab512;
	uop_t                 uop;
	mac_cmd_t             mac_cmd;
	mac_sts_t             mac_sts;
	div_sts_t             div_sts;
	logic [NW-1:0]        acc;
	logic signed [VW-1:0] op_a, op_b, quo;
	logic                 div_start, unit_done, out_free, out_load;
	logic [NW-1:0]        rnd_add, rnd_sum, rnd_q;
	logic                 rnd_ovf;
	logic signed [VW-1:0] rnd_val;

	assign k_s   = SW'(k_q);
	assign a_s   = SW'(a_q);
	assign b_s   = SW'(b_q);
	assign t_s   = (k_s <<< 9) + a_s + b_s;
	assign t256  = t_s + C256;
	assign t512  = t_s + C512;
	assign k1    = k_s + SW'(1);
	assign kab   = (k_s <<< 8) + a_s + b_s + C256;
	assign ka    = (k_s <<< 8) + a_s;
	assign kb    = (k_s <<< 8) + b_s;
	assign amb   = a_s - b_s;
	assign ab512 = a_s + b_s + C512;

	function automatic logic signed [VW-1:0] pick(input opsel_t s);
		logic signed [VW-1:0] v;
		unique case (s)
			OP_A:     v = VW'(a_s);
			OP_B:     v = VW'(b_s);
			OP_AMB:   v = VW'(amb);
			OP_AB512: v = VW'(ab512);
			OP_X:     v = VW'(x_q);
			OP_P30:   v = P30;
			OP_128:   v = D128;
			OP_T:     v = VW'(t_s);
			OP_T256:  v = VW'(t256);
			OP_T512:  v = VW'(t512);
			OP_K1:    v = VW'(k1);
			OP_KAB:   v = VW'(kab);
			OP_KA:    v = VW'(ka);
			OP_KB:    v = VW'(kb);
			OP_U:     v = u_q;
			OP_S:     v = s_q;
			OP_S2:    v = s_q <<< 1;
			OP_E:     v = VW'(e_q);
			OP_BC:    v = bc_q;
			OP_C:     v = c_q;
			OP_D:     v = d_q;
			OP_PC:    v = pc_q;
			OP_PM:    v = pm_q;
			OP_DC:    v = dc_q;
			OP_DM:    v = dm_q;
			OP_EC:    v = ec_q;
			OP_EM:    v = em_q;
			default:  v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uop           = uop_rom(upc_q);
		op_a          = pick(uop.opa);
		op_b          = pick(uop.opb);
		mac_cmd.start = (state_q == ST_RUN) && !issued_q && (uop.kind == UK_MAC);
		mac_cmd.clr   = uop.clr;
		mac_cmd.sub   = uop.sub;
		div_start     = (state_q == ST_RUN) && !issued_q && (uop.kind == UK_DIV);
		unit_done     = (uop.kind == UK_MAC) ? mac_sts.done
			: (uop.kind == UK_DIV) ? div_sts.done : 1'b1;
		out_free      = !ov_q || result.ready;
		out_load      = (state_q == ST_EMIT) && out_free;
		// round to nearest, ties away from zero: add half, less one when negative
		if (uop.opb == OP_P30)
			rnd_add = acc[NW-1] ? RND30_NEG : RND30_POS;
		else
			rnd_add = acc[NW-1] ? RND7_NEG : RND7_POS;
		rnd_sum = acc + rnd_add;
		rnd_q   = (uop.opb == OP_P30) ? NW'($signed(rnd_sum) >>> 30)
			: NW'($signed(rnd_sum) >>> 7);
		rnd_ovf = (rnd_q[NW-1:VW-1] != {(NW-VW+1){rnd_q[VW-1]}});
		rnd_val = rnd_ovf ? (rnd_q[NW-1] ? Q_MIN : Q_MAX) : rnd_q[VW-1:0];
	end

	jswd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.op_a   (op_a),
		.op_b   (op_b),
		.sts    (mac_sts),
		.acc    (acc)
	);

	jswd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc),
		.den    (op_b),
		.sts    (div_sts),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			upc_q    <= '0;
			issued_q <= 1'b0;
			k_q      <= '0;
			n_q      <= '0;
			x_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			u_q      <= '0;
			s_q      <= '0;
			d_q      <= '0;
			c_q      <= '0;
			e_q      <= '0;
			f_q      <= '0;
			bc_q     <= '0;
			pc_q     <= '0;
			pm_q     <= '0;
			dc_q     <= '0;
			dm_q     <= '0;
			ec_q     <= '0;
			em_q     <= '0;
			pn_q     <= '0;
			dn_q     <= '0;
			sat_q    <= 1'b0;
			ov_q     <= 1'b0;
			o_deg_q  <= '0;
			o_p_q    <= '0;
			o_d_q    <= '0;
			o_e_q    <= '0;
			o_sat_q  <= 1'b0;
			o_last_q <= 1'b0;
		end else begin
			if (ov_q && result.ready && !out_load)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						x_q   <= sample.point;
						a_q   <= sample.alpha_param;
						b_q   <= sample.beta_param;
						n_q   <= (sample.top_degree > MAX_DEGREE) ? KW'(MAX_DEGREE)
							: KW'(sample.top_degree);
						k_q   <= '0;
						pc_q  <= ONE_Q32;
						dc_q  <= '0;
						ec_q  <= '0;
						sat_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register can take the item
					if (out_load) begin
						ov_q     <= 1'b1;
						o_deg_q  <= 6'(k_q);
						o_p_q    <= pc_q;
						o_d_q    <= dc_q;
						o_e_q    <= ec_q;
						o_sat_q  <= sat_q;
						o_last_q <= (k_q == n_q);
						sat_q    <= 1'b0;
						issued_q <= 1'b0;
						upc_q    <= (k_q == '0) ? UPC_INIT : UPC_STEP;
						state_q  <= (k_q == n_q) ? ST_IDLE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (unit_done) begin
						issued_q <= 1'b0;
						unique case (uop.dst)
							DST_NONE: ;
							DST_U:  u_q <= acc[VW-1:0];
							DST_S:  s_q <= acc[VW-1:0];
							DST_D:  d_q <= {acc[VW-10:0], 9'b0};
							DST_C:  c_q <= {acc[VW-2:0], 1'b0};
							DST_E:  e_q <= acc[31:0];
							DST_F:  f_q <= acc[VW-1:0];
							DST_BC: bc_q <= rnd_val + f_q;
							DST_P1: begin
								pm_q  <= pc_q;
								pc_q  <= rnd_val;
								dm_q  <= dc_q;
								dc_q  <= VW'(ab512) <<< 23;
								em_q  <= ec_q;
								ec_q  <= '0;
								sat_q <= rnd_ovf;
								k_q   <= KW'(1);
							end
							DST_PN: begin
								pn_q  <= quo;
								sat_q <= sat_q | div_sts.sat;
							end
							DST_DN: begin
								dn_q  <= quo;
								sat_q <= sat_q | div_sts.sat;
							end
							DST_EN: begin
								// advance the recurrence by one degree
								pm_q  <= pc_q;
								pc_q  <= pn_q;
								dm_q  <= dc_q;
								dc_q  <= dn_q;
								em_q  <= ec_q;
								ec_q  <= quo;
								sat_q <= sat_q | div_sts.sat;
								k_q   <= k_q + KW'(1);
							end
							default: ;
						endcase
						if (uop.last)
							state_q <= ST_EMIT;
						else
							upc_q <= upc_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready        = (state_q == ST_IDLE);
	assign result.valid        = ov_q;
	assign result.degree       = o_deg_q;
	assign result.poly_value   = o_p_q;
	assign result.first_deriv  = o_d_q;
	assign result.second_deriv = o_e_q;
	assign result.saturated    = o_sat_q;
	assign result.last         = o_last_q;

	`JSWD_ASSERT(a_idle_units, sample.ready |-> (!mac_sts.busy && !div_sts.busy && !issued_q), "units busy while idle")
	`JSWD_NEVER(a_one_unit, mac_sts.busy && div_sts.busy, "multiplier and divider both busy")
	`JSWD_ASSERT(a_deg_bound, (state_q != ST_IDLE) |-> (k_q <= n_q), "degree past top degree")
endmodule

@@ hw/rtl/jswd_mac.sv @@
// Multiply-accumulate unit: 64x64 signed product into a 128-bit accumulator
// through one 32x32 multiplier by partial products. Depends on jswd_pkg.
`timescale 1ns / 1ps
module jswd_mac import jswd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_cmd_t             cmd,
	input  logic signed [VW-1:0] op_a,
	input  logic signed [VW-1:0] op_b,
	output mac_sts_t             sts,
	output logic [NW-1:0]        acc
);
	logic [VW-1:0] ma_q, mb_q;
	logic          neg_q;
	logic [2:0]    cnt_q;
	logic          busy_q, done_q;
	logic [63:0]   pp_s1;
	logic [1:0]    sh_s1;
	logic [NW-1:0] acc_q;
	logic [31:0]   ha, hb;
	logic [NW-1:0] ext;

	assign ha  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign hb  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign ext = NW'(pp_s1) << {sh_s1, 5'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Four partial products, each added or subtracted in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			ma_q  <= op_a[VW-1] ? (~op_a + 64'd1) : op_a;
			mb_q  <= op_b[VW-1] ? (~op_b + 64'd1) : op_b;
			neg_q <= op_a[VW-1] ^ op_b[VW-1] ^ cmd.sub;
			if (cmd.clr)
				acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= ha * hb;
				sh_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0)
				acc_q <= neg_q ? (acc_q - ext) : (acc_q + ext);
		end
	end

	assign acc      = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

@@ hw/rtl/jswd_div.sv @@
// Restoring divider: rounded signed 128/64 quotient, one bit per cycle,
// clipped to 64 bits. Depends on jswd_pkg.
`timescale 1ns / 1ps
module jswd_div import jswd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NW-1:0]        num,
	input  logic signed [VW-1:0] den,
	output div_sts_t             sts,
	output logic signed [VW-1:0] quo
);
	localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] NEG_MAX = {1'b1, {(VW-1){1'b0}}};

	logic [NW-1:0] work_q, nm;
	logic [VW-1:0] rem_q, dm_q, dm;
	logic          neg_q, busy_q, done_q, sat_q;
	logic [7:0]    cnt_q;
	logic [VW:0]   rem_sh;
	logic          ge, ovf;
	logic [VW-1:0] lim, quo_q;

	assign nm     = num[NW-1] ? (~num + 128'd1) : num;
	assign dm     = den[VW-1] ? (~den + 64'd1) : den;
	assign rem_sh = {rem_q, work_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, dm_q};
	assign lim    = neg_q ? NEG_MAX : POS_MAX;
	assign ovf    = (|work_q[NW-1:VW]) || (work_q[VW-1:0] > lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				cnt_q <= '0;
				if (den == '0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q[7]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q  <= num[NW-1] ^ den[VW-1];
			dm_q   <= dm;
			rem_q  <= '0;
			work_q <= nm + NW'(dm >> 1);
			// zero divisor: zero stays zero, anything else clips to its sign
			if (den == '0) begin
				sat_q <= |nm;
				quo_q <= (nm == '0) ? '0 : (num[NW-1] ? NEG_MAX : POS_MAX);
			end
		end else if (busy_q) begin
			if (cnt_q[7]) begin
				sat_q <= ovf;
				quo_q <= ovf ? lim : (neg_q ? (~work_q[VW-1:0] + 64'd1) : work_q[VW-1:0]);
			end else begin
				rem_q  <= ge ? VW'(rem_sh - {1'b0, dm_q}) : rem_sh[VW-1:0];
				work_q <= {work_q[NW-2:0], ge};
			end
		end
	end

	assign quo      = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.sat  = sat_q;
endmodule

@@ tb/sv/tb_jacobi_sequence_with_derivatives_core.sv @@
// Self-checking bench for the Jacobi sequence core: drives sample items, predicts
// every degree's P, P' and P'' in fixed point and compares each result item.
// Depends on jswd_pkg, jswd_in_if, jswd_out_if and the core itself.
`timescale 1ns / 1ps
module tb_jacobi_sequence_with_derivatives_core;
	import jswd_pkg::*;

	localparam int unsigned DEG_MAX = MAX_DEGREE_DEF;
	localparam longint CYCLE_LIMIT = 40000000;
	localparam longint Q32_ONE = 64'sh1_0000_0000;
	localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic [5:0]  degree;
		logic [63:0] poly_value;
		logic [63:0] first_deriv;
		logic [63:0] second_deriv;
		logic        saturated;
		logic        last;
	} term_t;

	logic clk;
	logic arst_n;
	jswd_in_if  smp();
	jswd_out_if res();

	jacobi_sequence_with_derivatives_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res)
	);

	term_t  pending_terms[$];
	int     src_gap_pct;
	int     snk_stall_pct;
	int     hold_cycles;
	longint cycles;
	bit     failed;

	always #5 clk = ~clk;

	// Product of two 64-bit values, exact in 128 bits.
	function automatic logic signed [127:0] mul_wide(input longint a, input longint b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// Rounded quotient, ties away from zero, clipped to 64 bits.
	function automatic longint div_round(input logic signed [127:0] num, input longint den,
			inout bit sat);
		logic [127:0] mag, quo;
		logic [63:0]  dmag, lim;
		bit           nneg, neg;
		nneg = num[127];
		mag = nneg ? -num : num;
		if (den == 0) begin
			if (mag == 0)
				return 0;
			sat = 1;
			return nneg ? S64_MIN : S64_MAX;
		end
		neg = nneg ^ (den < 0);
		dmag = (den < 0) ? -den : den;
		mag = mag + {64'b0, dmag >> 1};
		quo = mag / {64'b0, dmag};
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (quo[127:64] != 0 || quo[63:0] > lim) begin
			sat = 1;
			return neg ? S64_MIN : S64_MAX;
		end
		return neg ? -quo[63:0] : quo[63:0];
	endfunction

	function automatic term_t mk_term(input int k, input longint p, input longint d,
			input longint e, input bit sat, input bit lst);
		term_t t;
		t.degree = k[5:0];
		t.poly_value = p;
		t.first_deriv = d;
		t.second_deriv = e;
		t.saturated = sat;
		t.last = lst;
		return t;
	endfunction

	// Run the three-term recurrence and queue one expected item per degree.
	task automatic expand_jacobi(input logic signed [31:0] xv, input logic [5:0] nv,
			input logic signed [14:0] av, input logic signed [14:0] bv);
		longint x, a, b, pm, dm, em, pc, dc, ec, pn, dn, en;
		longint kk, t, den, s, c, bc;
		int     n;
		bit     sat, s2;
		x = xv;
		a = av;
		b = bv;
		n = nv;
		sat = 0;
		if (n > DEG_MAX)
			n = DEG_MAX;
		pm = Q32_ONE;
		dm = 0;
		em = 0;
		pending_terms.push_back(mk_term(0, pm, dm, em, 0, n == 0));
		if (n == 0)
			return;
		pc = div_round(mul_wide(a - b, 64'sd1 << 30) + mul_wide(a + b + 512, x), 128, sat);
		dc = (a + b + 512) * (64'sd1 << 23);
		ec = 0;
		pending_terms.push_back(mk_term(1, pc, dc, ec, sat, n == 1));
		for (int k = 1; k < n; k++) begin
			kk = k;
			t = 512 * kk + a + b;
			den = 512 * (kk + 1) * (256 * kk + a + b + 256) * t;
			s = (t + 256) * (t + 512) * t;
			c = 2 * (256 * kk + a) * (256 * kk + b) * (t + 512);
			s2 = 0;
			bc = div_round(mul_wide(s, x), 64'sd1 << 30, s2) + (t + 256) * (a * a - b * b);
			s2 = 0;
			pn = div_round(mul_wide(bc, pc) - mul_wide(c, pm), den, s2);
			dn = div_round(mul_wide(s, pc) + mul_wide(bc, dc) - mul_wide(c, dm), den, s2);
			en = div_round(mul_wide(2 * s, dc) + mul_wide(bc, ec) - mul_wide(c, em), den, s2);
			pending_terms.push_back(mk_term(k + 1, pn, dn, en, s2, k + 1 == n));
			pm = pc; pc = pn;
			dm = dc; dc = dn;
			em = ec; ec = en;
		end
	endtask

	// Offer one item from a falling edge and hold it until taken.
	task automatic send_item(input logic signed [31:0] xv, input logic [5:0] nv,
			input logic signed [14:0] av, input logic signed [14:0] bv);
		while ($urandom_range(99) < src_gap_pct) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.point <= xv;
		smp.top_degree <= nv;
		smp.alpha_param <= av;
		smp.beta_param <= bv;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		expand_jacobi(xv, nv, av, bv);
		@(negedge clk);
	endtask

	task automatic end_offer();
		smp.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_terms.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [14:0] rand_param();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 15'($signed($urandom_range(1279)) - 255);
		if (r < 90)
			return 15'($signed($urandom_range(16638)) - 255);
		return 15'($urandom);
	endfunction

	function automatic logic signed [31:0] rand_point();
		if ($urandom_range(99) < 90)
			return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
		return $urandom;
	endfunction

	function automatic logic [5:0] rand_degree();
		if ($urandom_range(99) < 95)
			return 6'($urandom_range(5));
		return 6'($urandom_range(63));
	endfunction

	task automatic test_directed();
		src_gap_pct = 0;
		snk_stall_pct = 0;
		send_item(32'sh2000_0000, 6'd5, 15'sd0, 15'sd0);            // Legendre at 0.5
		send_item(32'sh0, 6'd0, 15'sd0, 15'sd0);
		send_item(32'sh4000_0000, 6'd1, 15'sd256, 15'sd512);
		send_item(-32'sh4000_0000, 6'd3, -15'sd255, 15'sd16383);
		send_item(32'sh4000_0000, 6'd63, 15'sd0, 15'sd0);           // top degree, x = 1
		send_item(-32'sh4000_0000, 6'd8, 15'sd16383, 15'sd16383);   // drives clipping
		send_item(32'sh1234_5678, 6'd4, -15'sd256, -15'sd256);      // alpha = beta = -1
		send_item(32'sh0, 6'd4, -15'sd256, 15'sd100);               // x = 0, alpha = -1
		send_item(32'sh7fff_ffff, 6'd6, -15'sd16384, 15'sd16383);   // x and params off range
		send_item(32'sh8000_0000, 6'd6, 15'sd16383, -15'sd16384);
		send_item(32'shc000_0000, 6'd40, 15'sd128, -15'sd128);
		send_item(32'sh0400_0000, 6'd2, 15'sd16383, -15'sd255);
		end_offer();
		wait_drained();
	endtask

	task automatic test_random(input int count, input int gap, input int stall);
		src_gap_pct = gap;
		snk_stall_pct = stall;
		repeat (count)
			send_item(rand_point(), rand_degree(), rand_param(), rand_param());
		end_offer();
		wait_drained();
	endtask

	// Hold the receiver off while items keep coming, so the core backs up.
	task automatic test_backpressure();
		src_gap_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = 4000;
		repeat (4)
			send_item(rand_point(), 6'd2, rand_param(), rand_param());
		end_offer();
		wait_drained();
	endtask

	// Pause the sender until every pending item has come back.
	task automatic test_drain_pause();
		src_gap_pct = 0;
		snk_stall_pct = 30;
		repeat (6) begin
			send_item(rand_point(), rand_degree(), rand_param(), rand_param());
			end_offer();
			wait_drained();
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		term_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_terms.size() == 0) begin
				$display("%0t: result with nothing pending, degree %0d", $time, res.degree);
				failed = 1;
			end else begin
				want = pending_terms.pop_front();
				if (res.degree !== want.degree) begin
					$display("%0t: degree exp %0d got %0d", $time, want.degree, res.degree);
					failed = 1;
				end
				if (res.poly_value !== want.poly_value) begin
					$display("%0t: poly_value exp %h got %h", $time, want.poly_value,
						res.poly_value);
					failed = 1;
				end
				if (res.first_deriv !== want.first_deriv) begin
					$display("%0t: first_deriv exp %h got %h", $time, want.first_deriv,
						res.first_deriv);
					failed = 1;
				end
				if (res.second_deriv !== want.second_deriv) begin
					$display("%0t: second_deriv exp %h got %h", $time, want.second_deriv,
						res.second_deriv);
					failed = 1;
				end
				if (res.saturated !== want.saturated) begin
					$display("%0t: saturated exp %b got %b", $time, want.saturated,
						res.saturated);
					failed = 1;
				end
				if (res.last !== want.last) begin
					$display("%0t: last exp %b got %b", $time, want.last, res.last);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		failed = 0;
		hold_cycles = 0;
		src_gap_pct = 0;
		snk_stall_pct = 0;
		smp.valid = 1'b0;
		smp.point = '0;
		smp.top_degree = '0;
		smp.alpha_param = '0;
		smp.beta_param = '0;
		res.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(50, 0, 0);
		test_random(50, 87, 0);
		test_random(50, 0, 87);
		test_random(50, 36, 36);
		test_backpressure();
		test_drain_pause();
		repeat (200) @(posedge clk);
		if (!failed && pending_terms.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
